/* rtl/jls_pkg.sv */
`timescale 1ns / 1ps

package jls_pkg;

    localparam int SYS_N     = 4;
    localparam int IDX_W     = 2;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int TOL_W     = 23;
    localparam int ITER_W    = 8;
    // numerator: rhs minus three products of at most 2^46 each
    localparam int ACC_W     = 52;
    // dividend magnitude: clamped numerator scaled by 2^FRAC_W
    localparam int DIV_W     = 63;
    localparam int REM_W     = DATA_W + 1;
    localparam int DCNT_W    = 6;

    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'((1 << FRAC_W) / 100);
    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(100);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    localparam logic REG_TOL  = 1'b0;
    localparam logic REG_ITER = 1'b1;

    typedef logic [SYS_N-1:0][DATA_W-1:0] vec_t;

    typedef struct packed {
        logic done;
        logic settled;
    } lane_stat_t;

    // tridiagonal example system: 5 on the diagonal, 2 beside it
    function automatic logic [DATA_W-1:0] coef_reset(input int r, input int c);
        logic [DATA_W-1:0] v;
        v = '0;
        if (r == c)
            v = DATA_W'(5 << FRAC_W);
        else if (r == c + 1 || c == r + 1)
            v = DATA_W'(2 << FRAC_W);
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] rhs_reset(input int r);
        logic [DATA_W-1:0] v;
        v = '0;
        case (r)
            0: v = DATA_W'(12 << FRAC_W);
            1: v = DATA_W'(17 << FRAC_W);
            2: v = DATA_W'(14 << FRAC_W);
            3: v = DATA_W'(7 << FRAC_W);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/jls_lane.sv */
`timescale 1ns / 1ps

module jls_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  jls_pkg::vec_t               row,
    input  logic [jls_pkg::DATA_W-1:0]  rhs,
    input  jls_pkg::vec_t               old_x,
    input  logic [jls_pkg::TOL_W-1:0]   tol,
    output logic [jls_pkg::DATA_W-1:0]  new_x,
    output jls_pkg::lane_stat_t         stat
);
    import jls_pkg::*;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_MUL  = 3'd1;
    localparam logic [2:0] L_ACC  = 3'd2;
    localparam logic [2:0] L_PREP = 3'd3;
    localparam logic [2:0] L_DIV  = 3'd4;
    localparam logic [2:0] L_FIN  = 3'd5;
    localparam logic [2:0] L_CHK  = 3'd6;
    localparam logic [2:0] L_CMP  = 3'd7;

    localparam int D100_W = DATA_W + 8;
    localparam int TOLX_W = TOL_W + DATA_W;
    localparam int DSH_W  = D100_W + FRAC_W;

    localparam logic signed [ACC_W-1:0] NUM_LIM = ACC_W'(64'sd1 <<< (62 - FRAC_W));

    logic [2:0]               state_reg, state_next;
    logic [IDX_W-1:0]         col_reg;
    logic [DCNT_W-1:0]        cnt_reg;
    logic signed [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic [DIV_W-1:0]         dvd_reg;
    logic [DATA_W-1:0]        dvs_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         quo_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic [D100_W-1:0]        d100_reg;
    logic [TOLX_W-1:0]        tolx_reg;
    logic                     same_reg;
    logic                     done_reg;
    logic                     settled_reg;

    logic signed [DATA_W-1:0] coef_sel, old_sel, diag, old_own;
    logic signed [63:0]       term, prod_floor;
    logic signed [ACC_W-1:0]  acc_sub, num_clamp;
    logic [ACC_W-1:0]         num_mag;
    logic [REM_W-1:0]         rem_sh;
    logic                     geq;
    logic signed [DATA_W-1:0] q_sat;
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          diff_mag;
    logic [DATA_W-1:0]        new_mag;
    logic [DSH_W-1:0]         d_sh;

    assign coef_sel = signed'(row[col_reg]);
    assign old_sel  = signed'(old_x[col_reg]);
    assign diag     = signed'(row[LANE_IDX]);
    assign old_own  = signed'(old_x[LANE_IDX]);

    // the diagonal term takes no part in the numerator
    assign term       = (col_reg == IDX_W'(LANE_IDX)) ? 64'sd0 : coef_sel * old_sel;
    assign prod_floor = prod_reg >>> FRAC_W;
    assign acc_sub    = acc_reg - ACC_W'(prod_floor);

    always_comb
    begin
        num_clamp = acc_reg;
        if (acc_reg > NUM_LIM)
            num_clamp = NUM_LIM;
        else if (acc_reg < -NUM_LIM)
            num_clamp = -NUM_LIM;
        num_mag = num_clamp[ACC_W-1] ? ACC_W'(-num_clamp) : ACC_W'(num_clamp);
    end

    assign rem_sh = {rem_reg[REM_W-2:0], dvd_reg[DIV_W-1]};
    assign geq    = rem_sh >= {1'b0, dvs_reg};

    // sign and saturate the quotient magnitude
    always_comb
    begin
        if (neg_reg)
        begin
            if ((|quo_reg[DIV_W-1:DATA_W]) || (quo_reg[DATA_W-1] && (|quo_reg[DATA_W-2:0])))
                q_sat = {1'b1, {(DATA_W-1){1'b0}}};
            else
                q_sat = -signed'(quo_reg[DATA_W-1:0]);
        end
        else
        begin
            if (|quo_reg[DIV_W-1:DATA_W-1])
                q_sat = {1'b0, {(DATA_W-1){1'b1}}};
            else
                q_sat = signed'(quo_reg[DATA_W-1:0]);
        end
    end

    assign diff     = (DATA_W+1)'(x_reg) - (DATA_W+1)'(old_own);
    assign diff_mag = diff[DATA_W] ? unsigned'(-diff) : unsigned'(diff);
    assign new_mag  = x_reg[DATA_W-1] ? unsigned'(-x_reg) : unsigned'(x_reg);
    assign d_sh     = {d100_reg, {FRAC_W{1'b0}}};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE: if (start) state_next = L_MUL;
            L_MUL:  if (col_reg == IDX_W'(SYS_N - 1)) state_next = L_ACC;
            L_ACC:  state_next = L_PREP;
            L_PREP: state_next = L_DIV;
            L_DIV:  if (cnt_reg == DCNT_W'(DIV_W - 1)) state_next = L_FIN;
            L_FIN:  state_next = L_CHK;
            L_CHK:  state_next = L_CMP;
            L_CMP:  state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= L_IDLE;
            done_reg    <= 1'b0;
            settled_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_CMP);
            if (state_reg == L_CMP)
                // the product 100*|diff| stays below 2^40, so no overflow guard applies
                settled_reg <= same_reg || (d_sh < DSH_W'(tolx_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                col_reg  <= '0;
                prod_reg <= '0;
                acc_reg  <= ACC_W'(signed'(rhs));
            end
            L_MUL:
            begin
                prod_reg <= term;
                acc_reg  <= acc_sub;
                col_reg  <= col_reg + 1'b1;
            end
            L_ACC:
                acc_reg <= acc_sub;
            L_PREP:
            begin
                neg_reg <= num_clamp[ACC_W-1] ^ diag[DATA_W-1];
                dvd_reg <= DIV_W'(num_mag) << FRAC_W;
                dvs_reg <= diag[DATA_W-1] ? unsigned'(-diag) : unsigned'(diag);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            L_DIV:
            begin
                rem_reg <= geq ? rem_sh - {1'b0, dvs_reg} : rem_sh;
                quo_reg <= {quo_reg[DIV_W-2:0], geq};
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            L_FIN:
                x_reg <= q_sat;
            L_CHK:
            begin
                d100_reg <= D100_W'(diff_mag) * D100_W'(100);
                tolx_reg <= TOLX_W'(tol) * TOLX_W'(new_mag);
                same_reg <= (x_reg == old_own);
            end
            default: ;
        endcase
    end

    assign new_x        = x_reg;
    assign stat.done    = done_reg;
    assign stat.settled = settled_reg;

endmodule

/* rtl/jacobi_linear_solver_core.sv */
`timescale 1ns / 1ps

// Jacobi solver for a 4x4 system in signed Q16.16.
// Input channel (in_valid / in_stall): command 0 loads one matrix row
// (coef_0..coef_3, rhs) at row_index; command 1 runs a solve from a zero
// estimate. Each item yields exactly one result item on the output channel
// (out_valid / out_stall): x_0..x_3, sweeps_done, converged, zero_pivot.
// A load, or a solve stopped by a zero diagonal or a zero sweep limit, goes
// to the done state and raises out_valid once the output register is free.
// A solve runs whole sweeps; in each sweep four lanes compute one component
// each: multiply-accumulate steps over the four columns, one step to fold in
// the last product, one to set up a radix-2 divider, then the divider and a
// convergence check. A sweep runs from the kick state through the lanes to
// the merge; out_valid rises after the last sweep, once the done state finds
// the output register free. One item is worked on at a time.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 tolerance in
// percent, index 1 sweep limit. Write only while the block is idle.
// Reset restores the example tridiagonal system, tolerance 0.01 percent and
// a limit of 100 sweeps, and empties the output register.
// While the receiver stalls the result is held and the next item is still
// taken; its own result waits until the output register frees up.

module jacobi_linear_solver_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [1:0]                  row_index,
    input  logic signed [31:0]          coef_0,
    input  logic signed [31:0]          coef_1,
    input  logic signed [31:0]          coef_2,
    input  logic signed [31:0]          coef_3,
    input  logic signed [31:0]          rhs,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          x_0,
    output logic signed [31:0]          x_1,
    output logic signed [31:0]          x_2,
    output logic signed [31:0]          x_3,
    output logic [7:0]                  sweeps_done,
    output logic                        converged,
    output logic                        zero_pivot,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [22:0]                 cfg_data
);
    import jls_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_KICK  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg;
    vec_t              coef_reg [SYS_N];
    vec_t              rhs_reg;
    vec_t              old_x_reg;
    vec_t              res_x_reg;
    logic [ITER_W-1:0] sweep_reg;
    logic              res_conv_reg;
    logic              res_piv_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              out_valid_reg;
    vec_t              out_x_reg;
    logic [ITER_W-1:0] out_sweeps_reg;
    logic              out_conv_reg;
    logic              out_piv_reg;

    logic              in_fire;
    logic              out_free;
    logic              diag_zero;
    logic              lane_start;
    vec_t              lane_x;
    lane_stat_t        lane_stat [SYS_N];
    logic              all_done;
    logic              all_settled;
    logic [ITER_W-1:0] sweep_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign lane_start = (state_reg == S_KICK);
    assign sweep_next = sweep_reg + 1'b1;

    always_comb
    begin
        diag_zero = 1'b0;
        for (int i = 0; i < SYS_N; i++)
            if (coef_reg[i][i] == '0)
                diag_zero = 1'b1;
    end

    // merge: a sweep ends when every lane reports, and converges only if all settled
    always_comb
    begin
        all_done    = 1'b1;
        all_settled = 1'b1;
        for (int i = 0; i < SYS_N; i++)
        begin
            all_done    = all_done && lane_stat[i].done;
            all_settled = all_settled && lane_stat[i].settled;
        end
    end

    for (genvar g = 0; g < SYS_N; g++)
    begin : g_lane
        jls_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start),
            .row   (coef_reg[g]),
            .rhs   (rhs_reg[g]),
            .old_x (old_x_reg),
            .tol   (tol_reg),
            .new_x (lane_x[g]),
            .stat  (lane_stat[g])
        );
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= TOL_RESET;
            iter_reg <= ITER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TOL:  tol_reg  <= cfg_data;
                REG_ITER: iter_reg <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient and right-hand side stores; reset to the example system
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SYS_N; r++)
            begin
                for (int c = 0; c < SYS_N; c++)
                    coef_reg[r][c] <= coef_reset(r, c);
                rhs_reg[r] <= rhs_reset(r);
            end
        end
        else if (in_fire && command == CMD_LOAD)
        begin
            coef_reg[row_index] <= {coef_3, coef_2, coef_1, coef_0};
            rhs_reg[row_index]  <= rhs;
        end
    end

    // sweep sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // hand the result over once the output register frees up
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (command == CMD_SOLVE && !diag_zero && iter_reg != '0)
                            state_reg <= S_KICK;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_KICK:
                    state_reg <= S_SWEEP;
                S_SWEEP:
                begin
                    if (all_done)
                    begin
                        if (all_settled || sweep_next == iter_reg)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_KICK;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            old_x_reg    <= '0;
            res_x_reg    <= '0;
            sweep_reg    <= '0;
            res_conv_reg <= 1'b0;
            res_piv_reg  <= (command == CMD_SOLVE) && diag_zero;
        end
        else if (state_reg == S_SWEEP && all_done)
        begin
            sweep_reg    <= sweep_next;
            res_x_reg    <= lane_x;
            old_x_reg    <= lane_x;
            res_conv_reg <= all_settled;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_x_reg      <= res_x_reg;
            out_sweeps_reg <= sweep_reg;
            out_conv_reg   <= res_conv_reg;
            out_piv_reg    <= res_piv_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_0         = signed'(out_x_reg[0]);
    assign x_1         = signed'(out_x_reg[1]);
    assign x_2         = signed'(out_x_reg[2]);
    assign x_3         = signed'(out_x_reg[3]);
    assign sweeps_done = out_sweeps_reg;
    assign converged   = out_conv_reg;
    assign zero_pivot  = out_piv_reg;

endmodule

/* rtl/jls_checker.sv */
`timescale 1ns / 1ps

module jls_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic signed [31:0] x_0,
    input logic [7:0]        sweeps_done,
    input logic              converged,
    input logic              zero_pivot
);

    // a result held by the receiver stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_0) && $stable(sweeps_done))
        else $error("stalled result item changed");

    // the block takes one item at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    a_pivot_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_pivot |-> !converged && sweeps_done == 8'd0 && x_0 == 32'sd0)
        else $error("zero pivot result not cleared");

    a_conv_swept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && converged |-> sweeps_done != 8'd0)
        else $error("converged without a sweep");

endmodule

bind jacobi_linear_solver_core jls_checker u_jls_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_0         (x_0),
    .sweeps_done (sweeps_done),
    .converged   (converged),
    .zero_pivot  (zero_pivot)
);
